[hw/rtl/atr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_pkg
// Shared types and constants for the audio tag header recognizer.
// ----------------------------------------------------------------------------
package atr_pkg;

    // Window geometry
    localparam int WINDOW_BYTES = 4096;
    localparam int IDX_W        = 17;
    localparam int HDR_DEPTH    = 32;
    localparam int HDR_IDX_W    = 5;
    localparam int LEN_W        = 33;

    // Header positions
    localparam int ID3V2_HDR_LAST = 9;
    localparam int APE_HDR_LAST   = 31;
    localparam int ID3V1_HDR_LAST = 2;
    localparam int ID3V1X_HDR_LAST = 3;

    // Signatures
    localparam logic [23:0] ID3_MAGIC     = "ID3";
    localparam logic [63:0] APE_MAGIC     = "APETAGEX";
    localparam logic [23:0] TAG_MAGIC     = "TAG";
    localparam logic [31:0] TAG_EXT_MAGIC = "TAG+";

    // Field values
    localparam logic [31:0] APE_VER_1000   = 32'd1000;
    localparam logic [31:0] APE_VER_2000   = 32'd2000;
    localparam logic [7:0]  BYTE_ALL_ONES  = 8'hff;
    localparam logic [7:0]  ID3_FOOTER_BIT = 8'h10;
    localparam logic [7:0]  APE_HEADER_BIT = 8'h80;

    // Lengths
    localparam logic [LEN_W-1:0] ID3V2_HDR_LEN  = 33'd10;
    localparam logic [LEN_W-1:0] ID3V2_FTR_LEN  = 33'd10;
    localparam logic [LEN_W-1:0] APE_HDR_LEN    = 33'd32;
    localparam logic [LEN_W-1:0] ID3V1_LEN      = 33'd128;
    localparam logic [LEN_W-1:0] ID3V1_EXT_LEN  = 33'd227;

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_ID3V2     = 3'd1,
        KIND_APE       = 3'd2,
        KIND_ID3V1     = 3'd3,
        KIND_ID3V1_EXT = 3'd4
    } tag_kind_t;

    typedef enum logic [1:0] {
        REGION_START      = 2'd0,
        REGION_ID3V1      = 2'd1,
        REGION_ID3V1_EXT  = 2'd2,
        REGION_APE_FOOTER = 2'd3
    } region_t;

    typedef struct packed {
        logic [7:0] data_byte;
        region_t    region;
        logic       window_last;
    } atr_item_t;

    typedef struct packed {
        tag_kind_t        tag_kind;
        logic [LEN_W-1:0] tag_length;
    } atr_result_t;

endpackage

[hw/rtl/audio_tag_header_recognizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_tag_header_recognizer
// Scans one window of audio file bytes for ID3v2, APE, ID3v1 and extended
// ID3v1 tags and reports the tag kind and length on the last byte.
// ----------------------------------------------------------------------------
// Result path: the last byte's transfer loads the input register, and the
//   result register loads when the scan stage takes that byte.
// Throughput: one byte per cycle; a closing byte waits only while the result
//   register still holds an untaken result.
// Reset: synchronous active-low aresetn clears the handshake valids and the
//   window position; captured header bytes are not cleared.
module audio_tag_header_recognizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [1:0]  s_region,
    input  logic        s_window_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_tag_kind,
    output logic [32:0] m_tag_length
);

    atr_pkg::atr_item_t   s_item;
    atr_pkg::atr_item_t   q_item;
    logic                 q_valid;
    logic                 q_take;
    logic                 out_free;
    logic                 r_valid;
    atr_pkg::atr_result_t r_result;
    atr_pkg::atr_result_t m_result;

    // Pack input ports
    assign s_item.data_byte   = s_data_byte;
    assign s_item.region      = atr_pkg::region_t'(s_region);
    assign s_item.window_last = s_window_last;

    atr_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_take  (q_take)
    );

    atr_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_take   (q_take),
        .out_free (out_free),
        .r_valid  (r_valid),
        .r_result (r_result)
    );

    atr_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .r_valid  (r_valid),
        .r_result (r_result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // Unpack result ports
    assign m_tag_kind   = m_result.tag_kind;
    assign m_tag_length = m_result.tag_length;

endmodule

[hw/rtl/atr_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_in_reg
// Input register: holds one accepted byte until the scan stage takes it.
// ----------------------------------------------------------------------------
module atr_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  atr_pkg::atr_item_t s_item,
    output logic              q_valid,
    output atr_pkg::atr_item_t q_item,
    input  logic              q_take
);

    logic               valid_reg;
    logic               valid_next;
    atr_pkg::atr_item_t item_reg;

    // Accept when empty or when the held item leaves this cycle
    assign s_ready    = !valid_reg || q_take;
    assign valid_next = s_valid || (valid_reg && !q_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on each input transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

[hw/rtl/atr_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_scan
// Window scan: captures header bytes, tracks ID3v2 padding and decides the
// tag kind and length on the last byte of a window.
// ----------------------------------------------------------------------------
module atr_scan (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  atr_pkg::atr_item_t   q_item,
    output logic                 q_take,
    input  logic                 out_free,
    output logic                 r_valid,
    output atr_pkg::atr_result_t r_result
);

    logic [atr_pkg::IDX_W-1:0] byte_index_reg;
    logic [atr_pkg::IDX_W-1:0] byte_index_next;
    logic [atr_pkg::LEN_W-1:0] tag_end_reg;
    logic [atr_pkg::LEN_W-1:0] tag_end_next;
    logic [atr_pkg::LEN_W-1:0] tag_end_upd;
    logic                      padding_open_reg;
    logic                      padding_open_next;
    logic                      padding_open_upd;
    atr_pkg::region_t          region_latched_reg;
    atr_pkg::region_t          region_latched_next;
    logic [7:0]                header_bytes_reg [atr_pkg::HDR_DEPTH];

    logic [atr_pkg::IDX_W-1:0] idx;
    logic [7:0]                b;
    logic                      last_eff;
    atr_pkg::region_t          region_eff;
    logic [7:0]                hb [atr_pkg::HDR_DEPTH];

    logic                      id3_fields_ok;
    logic [atr_pkg::LEN_W-1:0] id3_base;
    logic                      id3_found;
    logic [31:0]               ape_ver;
    logic                      ape_found;
    logic [atr_pkg::LEN_W-1:0] ape_len;
    logic                      tag_found;
    logic                      tag_ext_found;

    assign idx      = byte_index_reg;
    assign b        = q_item.data_byte;
    assign last_eff = q_item.window_last ||
                      (idx == atr_pkg::IDX_W'(atr_pkg::WINDOW_BYTES - 1));
    assign region_eff = (idx == '0) ? q_item.region : region_latched_reg;

    // Take a byte unless it closes a window and the result slot is busy
    assign q_take  = q_valid && (!last_eff || out_free);
    assign r_valid = q_take && last_eff;

    // Header view with the current byte merged in
    always_comb begin
        for (int i = 0; i < atr_pkg::HDR_DEPTH; i++) begin
            hb[i] = (idx == atr_pkg::IDX_W'(i)) ? b : header_bytes_reg[i];
        end
    end

    // ID3v2 header checks and base length
    assign id3_fields_ok = ({hb[0], hb[1], hb[2]} == atr_pkg::ID3_MAGIC) &&
                           (hb[3] != atr_pkg::BYTE_ALL_ONES) &&
                           (hb[4] != atr_pkg::BYTE_ALL_ONES) &&
                           !hb[6][7] && !hb[7][7] && !hb[8][7] && !hb[9][7];
    assign id3_base = {5'd0, hb[6][6:0], hb[7][6:0], hb[8][6:0], hb[9][6:0]}
                    + atr_pkg::ID3V2_HDR_LEN
                    + (((hb[5] & atr_pkg::ID3_FOOTER_BIT) != 8'd0) ?
                       atr_pkg::ID3V2_FTR_LEN : '0);
    assign id3_found = id3_fields_ok && (idx >= atr_pkg::IDX_W'(atr_pkg::ID3V2_HDR_LAST));

    // APE header or footer checks and length
    assign ape_ver   = {hb[11], hb[10], hb[9], hb[8]};
    assign ape_found = (idx >= atr_pkg::IDX_W'(atr_pkg::APE_HDR_LAST)) &&
                       ({hb[0], hb[1], hb[2], hb[3], hb[4], hb[5], hb[6], hb[7]}
                        == atr_pkg::APE_MAGIC) &&
                       ((ape_ver == atr_pkg::APE_VER_1000) ||
                        (ape_ver == atr_pkg::APE_VER_2000)) &&
                       ({hb[24], hb[25], hb[26], hb[27],
                         hb[28], hb[29], hb[30], hb[31]} == 64'd0);
    assign ape_len = {1'b0, hb[15], hb[14], hb[13], hb[12]}
                   + (((ape_ver == atr_pkg::APE_VER_2000) &&
                       ((hb[23] & atr_pkg::APE_HEADER_BIT) != 8'd0)) ?
                      atr_pkg::APE_HDR_LEN : '0);

    // ID3v1 and extended ID3v1 checks
    assign tag_found = (idx >= atr_pkg::IDX_W'(atr_pkg::ID3V1_HDR_LAST)) &&
                       ({hb[0], hb[1], hb[2]} == atr_pkg::TAG_MAGIC);
    assign tag_ext_found = (idx >= atr_pkg::IDX_W'(atr_pkg::ID3V1X_HDR_LAST)) &&
                           ({hb[0], hb[1], hb[2], hb[3]} == atr_pkg::TAG_EXT_MAGIC);

    // Track ID3v2 tag end, extending it over zero padding
    always_comb begin
        tag_end_upd      = tag_end_reg;
        padding_open_upd = padding_open_reg;
        if (region_eff == atr_pkg::REGION_START) begin
            if (idx == atr_pkg::IDX_W'(atr_pkg::ID3V2_HDR_LAST)) begin
                if (id3_fields_ok) begin
                    tag_end_upd      = id3_base;
                    padding_open_upd = 1'b1;
                end else begin
                    padding_open_upd = 1'b0;
                end
            end else if ((idx > atr_pkg::IDX_W'(atr_pkg::ID3V2_HDR_LAST)) &&
                         padding_open_reg &&
                         ({{(atr_pkg::LEN_W - atr_pkg::IDX_W){1'b0}}, idx} == tag_end_reg)) begin
                if (b == 8'd0) begin
                    tag_end_upd = tag_end_reg + atr_pkg::LEN_W'(1);
                end else begin
                    padding_open_upd = 1'b0;
                end
            end
        end
    end

    // Advance window position; return to reset after the last byte
    always_comb begin
        if (last_eff) begin
            byte_index_next     = '0;
            region_latched_next = atr_pkg::REGION_START;
            tag_end_next        = '0;
            padding_open_next   = 1'b0;
        end else begin
            byte_index_next     = idx + atr_pkg::IDX_W'(1);
            region_latched_next = region_eff;
            tag_end_next        = tag_end_upd;
            padding_open_next   = padding_open_upd;
        end
    end

    // Select the result for the latched region
    always_comb begin
        r_result.tag_kind   = atr_pkg::KIND_NONE;
        r_result.tag_length = '0;
        case (region_eff)
            atr_pkg::REGION_START: begin
                if (id3_found) begin
                    r_result.tag_kind   = atr_pkg::KIND_ID3V2;
                    r_result.tag_length = tag_end_upd;
                end else if (ape_found) begin
                    r_result.tag_kind   = atr_pkg::KIND_APE;
                    r_result.tag_length = ape_len;
                end
            end
            atr_pkg::REGION_ID3V1: begin
                if (tag_found) begin
                    r_result.tag_kind   = atr_pkg::KIND_ID3V1;
                    r_result.tag_length = atr_pkg::ID3V1_LEN;
                end
            end
            atr_pkg::REGION_ID3V1_EXT: begin
                if (tag_ext_found) begin
                    r_result.tag_kind   = atr_pkg::KIND_ID3V1_EXT;
                    r_result.tag_length = atr_pkg::ID3V1_EXT_LEN;
                end
            end
            default: begin
                if (ape_found) begin
                    r_result.tag_kind   = atr_pkg::KIND_APE;
                    r_result.tag_length = ape_len;
                end
            end
        endcase
    end

    // Window state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg     <= '0;
            region_latched_reg <= atr_pkg::REGION_START;
            tag_end_reg        <= '0;
            padding_open_reg   <= 1'b0;
        end else if (q_take) begin
            byte_index_reg     <= byte_index_next;
            region_latched_reg <= region_latched_next;
            tag_end_reg        <= tag_end_next;
            padding_open_reg   <= padding_open_next;
        end
    end

    // Capture the first header bytes of the window
    always_ff @(posedge aclk) begin
        if (q_take && (idx < atr_pkg::IDX_W'(atr_pkg::HDR_DEPTH))) begin
            header_bytes_reg[idx[atr_pkg::HDR_IDX_W-1:0]] <= b;
        end
    end

endmodule

[hw/rtl/atr_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_out_reg
// Result register: holds one result until the downstream transfer.
// ----------------------------------------------------------------------------
module atr_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 r_valid,
    input  atr_pkg::atr_result_t r_result,
    output logic                 out_free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output atr_pkg::atr_result_t m_result
);

    logic                 valid_reg;
    atr_pkg::atr_result_t result_reg;

    // Slot is free when empty or draining this cycle
    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= r_valid;
        end
    end

    // Load a new result only into a free slot
    always_ff @(posedge aclk) begin
        if (r_valid && out_free) begin
            result_reg <= r_result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

[hw/rtl/atr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_port_checker
// Port-level checks for the audio tag header recognizer, bound to the top.
// ----------------------------------------------------------------------------
module atr_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_data_byte,
    input logic [1:0]  s_region,
    input logic        s_window_last,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_tag_kind,
    input logic [32:0] m_tag_length
);

    // Hold a stalled byte with its payload
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=>
        (s_valid && $stable({s_data_byte, s_region, s_window_last})))
        else $error("byte changed while stalled");

    // Hold a stalled result with its payload
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_tag_kind) && $stable(m_tag_length)))
        else $error("result changed while stalled");

    // No tag means zero length
    a_none_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_tag_kind == atr_pkg::KIND_NONE)) |-> (m_tag_length == '0))
        else $error("nonzero length without a tag");

    // ID3v1 tags have fixed lengths
    a_v1_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
        ((m_tag_kind != atr_pkg::KIND_ID3V1) || (m_tag_length == atr_pkg::ID3V1_LEN)) &&
        ((m_tag_kind != atr_pkg::KIND_ID3V1_EXT) ||
         (m_tag_length == atr_pkg::ID3V1_EXT_LEN)))
        else $error("bad ID3v1 length");

    // A rising result needs a byte transfer to have come before it
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a window");

endmodule

bind audio_tag_header_recognizer atr_port_checker u_atr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_data_byte   (s_data_byte),
    .s_region      (s_region),
    .s_window_last (s_window_last),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_tag_kind    (m_tag_kind),
    .m_tag_length  (m_tag_length)
);

[dv/atr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_checker
// Watches the byte and result channels of the audio tag header recognizer.
// Keeps its own copy of the window state, works out the tag kind and length
// each closing byte should give, and compares every result transfer with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module atr_checker
    import atr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [1:0]  s_region,
    input  logic        s_window_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_tag_kind,
    input  logic [32:0] m_tag_length,
    output int          fail_count,
    output int          tags_pending
);

    localparam logic [7:0] SYNCHSAFE_LIMIT = 8'h80;

    // Window state, mirrored from the byte stream
    logic [IDX_W-1:0] win_pos;
    logic [7:0]       hdr [HDR_DEPTH];
    logic [LEN_W-1:0] id3_end;
    logic             pad_open;
    region_t          win_region;

    // Tags still owed by the block, oldest first
    atr_result_t      expected_tags[$];

    function automatic logic [31:0] hdr_le32(int p);
        return {hdr[p+3], hdr[p+2], hdr[p+1], hdr[p]};
    endfunction

    function automatic bit id3v2_seen(int unsigned n);
        return n > ID3V2_HDR_LAST
            && {hdr[0], hdr[1], hdr[2]} == ID3_MAGIC
            && hdr[3] != BYTE_ALL_ONES && hdr[4] != BYTE_ALL_ONES
            && hdr[6] < SYNCHSAFE_LIMIT && hdr[7] < SYNCHSAFE_LIMIT
            && hdr[8] < SYNCHSAFE_LIMIT && hdr[9] < SYNCHSAFE_LIMIT;
    endfunction

    // Synchsafe size plus header, plus footer when flagged
    function automatic logic [LEN_W-1:0] id3v2_extent();
        logic [LEN_W-1:0] ext;
        ext = (LEN_W'(hdr[6]) << 21) | (LEN_W'(hdr[7]) << 14)
            | (LEN_W'(hdr[8]) << 7) | LEN_W'(hdr[9]);
        ext = ext + ID3V2_HDR_LEN;
        if ((hdr[5] & ID3_FOOTER_BIT) != 8'h00) begin
            ext = ext + ID3V2_FTR_LEN;
        end
        return ext;
    endfunction

    function automatic bit ape_seen(int unsigned n);
        logic [31:0] ver;
        ver = hdr_le32(8);
        return n > APE_HDR_LAST
            && {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5], hdr[6], hdr[7]} == APE_MAGIC
            && (ver == APE_VER_1000 || ver == APE_VER_2000)
            && {hdr[24], hdr[25], hdr[26], hdr[27],
                hdr[28], hdr[29], hdr[30], hdr[31]} == 64'd0;
    endfunction

    // Size field taken unsigned; header bit only counts for version 2000
    function automatic logic [LEN_W-1:0] ape_extent();
        logic [LEN_W-1:0] ext;
        ext = LEN_W'(hdr_le32(12));
        if (hdr_le32(8) == APE_VER_2000 && (hdr[23] & APE_HEADER_BIT) != 8'h00) begin
            ext = ext + APE_HDR_LEN;
        end
        return ext;
    endfunction

    function automatic atr_result_t classify_window(int unsigned n);
        atr_result_t tag;
        tag.tag_kind   = KIND_NONE;
        tag.tag_length = '0;
        case (win_region)
            REGION_START: begin
                if (id3v2_seen(n)) begin
                    tag.tag_kind   = KIND_ID3V2;
                    tag.tag_length = id3_end;
                end else if (ape_seen(n)) begin
                    tag.tag_kind   = KIND_APE;
                    tag.tag_length = ape_extent();
                end
            end
            REGION_ID3V1: begin
                if (n > ID3V1_HDR_LAST && {hdr[0], hdr[1], hdr[2]} == TAG_MAGIC) begin
                    tag.tag_kind   = KIND_ID3V1;
                    tag.tag_length = ID3V1_LEN;
                end
            end
            REGION_ID3V1_EXT: begin
                if (n > ID3V1X_HDR_LAST
                        && {hdr[0], hdr[1], hdr[2], hdr[3]} == TAG_EXT_MAGIC) begin
                    tag.tag_kind   = KIND_ID3V1_EXT;
                    tag.tag_length = ID3V1_EXT_LEN;
                end
            end
            default: begin
                if (ape_seen(n)) begin
                    tag.tag_kind   = KIND_APE;
                    tag.tag_length = ape_extent();
                end
            end
        endcase
        return tag;
    endfunction

    task automatic log_mismatch(string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] %s: got kind %0d length %0d", $time, what,
                     m_tag_kind, m_tag_length);
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        logic [IDX_W-1:0] idx;
        atr_result_t      want;
        if (!aresetn) begin
            win_pos    = '0;
            id3_end    = '0;
            pad_open   = 1'b0;
            win_region = REGION_START;
            foreach (hdr[i]) hdr[i] = 8'h00;
            expected_tags.delete();
        end else begin
            // Match a result transfer against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_tags.size() == 0) begin
                    log_mismatch("result with none outstanding");
                end else begin
                    want = expected_tags.pop_front();
                    if (m_tag_kind !== want.tag_kind || m_tag_length !== want.tag_length) begin
                        log_mismatch($sformatf("expected kind %0d length %0d",
                                               want.tag_kind, want.tag_length));
                    end
                end
            end

            // Advance the window on a byte transfer
            if (s_valid && s_ready) begin
                idx = win_pos;
                if (idx == '0) begin
                    win_region = region_t'(s_region);
                end
                if (idx < HDR_DEPTH) begin
                    hdr[idx[HDR_IDX_W-1:0]] = s_data_byte;
                end

                // Track the ID3v2 end, then grow it over zero padding
                if (win_region == REGION_START) begin
                    if (idx == ID3V2_HDR_LAST) begin
                        pad_open = id3v2_seen(ID3V2_HDR_LAST + 1);
                        if (pad_open) begin
                            id3_end = id3v2_extent();
                        end
                    end else if (idx > ID3V2_HDR_LAST && pad_open
                                 && LEN_W'(idx) == id3_end) begin
                        if (s_data_byte == 8'h00) begin
                            id3_end = id3_end + 1'b1;
                        end else begin
                            pad_open = 1'b0;
                        end
                    end
                end

                // Close on the last mark or when the window is full
                if (s_window_last || int'(idx) + 1 >= WINDOW_BYTES) begin
                    expected_tags.push_back(classify_window(int'(idx) + 1));
                    win_pos    = '0;
                    id3_end    = '0;
                    pad_open   = 1'b0;
                    win_region = REGION_START;
                end else begin
                    win_pos = idx + 1'b1;
                end
            end
        end
        tags_pending = expected_tags.size();
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte windows into the audio tag header recognizer: directed tag
// headers and their edge cases first, then random well-formed, broken and
// noise windows, with random pacing on both channels. Results are checked by
// atr_checker.
// ----------------------------------------------------------------------------
module testbench;
    import atr_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_BYTES   = 800;
    localparam int RANDOM_WINDOWS = 60;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte   = 8'h00;
    logic [1:0]  s_region      = 2'd0;
    logic        s_window_last = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [2:0]  m_tag_kind;
    logic [32:0] m_tag_length;

    int          fail_count;
    int          tags_pending;
    int unsigned cycle_count = 0;

    logic [7:0]  win_bytes[$];
    int          bytes_sent   = 0;
    int          windows_sent = 0;
    bit          send_calm    = 1'b0;
    bit          take_calm    = 1'b0;
    int          take_hold    = 0;

    audio_tag_header_recognizer i_dut (.*);

    atr_checker i_checker (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones; none while calm
    function automatic int pick_gap(bit calm);
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // Pace the result channel
    always @(posedge aclk) begin : sink_pace
        if ($urandom_range(0, 49) == 0) take_calm = !take_calm;
        if (take_hold > 0) begin
            take_hold--;
            m_ready <= 1'b0;
        end else begin
            take_hold = pick_gap(take_calm);
            m_ready <= (take_hold == 0);
        end
    end

    // Give up on a hung run
    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL audio_tag_header_recognizer");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, logic [1:0] r, logic l);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_region      <= r;
        s_window_last <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Send the buffered window; later bytes carry a random region
    task automatic send_window(region_t r);
        for (int i = 0; i < win_bytes.size(); i++) begin
            send_byte(win_bytes[i], (i == 0) ? 2'(r) : 2'($urandom_range(0, 3)),
                      i == win_bytes.size() - 1);
        end
        win_bytes.delete();
        windows_sent++;
    endtask

    task automatic trim_window(int n);
        while (win_bytes.size() > n) void'(win_bytes.pop_back());
    endtask

    task automatic push_le32(logic [31:0] v);
        for (int i = 0; i < 4; i++) win_bytes.push_back(v[8*i +: 8]);
    endtask

    // ID3v2 header, body up to the tag end, zero padding, then a nonzero
    // terminator and tail bytes
    task automatic build_id3v2(logic [7:0] ver, logic [7:0] flags, logic [7:0] s6,
                               logic [7:0] s7, logic [7:0] s8, logic [7:0] s9,
                               int pad, int tail);
        longint body_end;
        for (int i = 0; i < 3; i++) win_bytes.push_back(ID3_MAGIC[23 - 8*i -: 8]);
        win_bytes.push_back(ver);
        win_bytes.push_back(8'($urandom_range(0, 254)));
        win_bytes.push_back(flags);
        win_bytes.push_back(s6);
        win_bytes.push_back(s7);
        win_bytes.push_back(s8);
        win_bytes.push_back(s9);
        body_end = {s6[6:0], s7[6:0], s8[6:0], s9[6:0]} + 10
                 + (((flags & ID3_FOOTER_BIT) != 8'h00) ? 10 : 0);
        if (body_end > 200) body_end = 10;
        while (win_bytes.size() < body_end) win_bytes.push_back(8'($urandom));
        repeat (pad) win_bytes.push_back(8'h00);
        if (tail > 0) begin
            win_bytes.push_back(8'($urandom_range(1, 255)));
            repeat (tail - 1) win_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic build_ape(logic [31:0] ver, logic [31:0] size, logic [7:0] flags23,
                             int extra);
        for (int i = 0; i < 8; i++) win_bytes.push_back(APE_MAGIC[63 - 8*i -: 8]);
        push_le32(ver);
        push_le32(size);
        push_le32($urandom);
        repeat (3) win_bytes.push_back(8'($urandom));
        win_bytes.push_back(flags23);
        repeat (8) win_bytes.push_back(8'h00);
        repeat (extra) win_bytes.push_back(8'($urandom));
    endtask

    task automatic build_tag(bit ext, int extra);
        for (int i = 0; i < 3; i++) win_bytes.push_back(TAG_MAGIC[23 - 8*i -: 8]);
        if (ext) win_bytes.push_back(TAG_EXT_MAGIC[7:0]);
        repeat (extra) win_bytes.push_back(8'($urandom));
    endtask

    initial begin : stimulus
        int          pick;
        int          n;
        int          lim;
        region_t     rgn;
        logic [31:0] ape_ver;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // ID3v2: bare header, largest size with footer, bad version bytes,
        // bad size byte, padding cut by a nonzero byte, padding to window end,
        // one byte short
        build_id3v2(8'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0);
        send_window(REGION_START);
        build_id3v2(8'd4, ID3_FOOTER_BIT, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 0, 2);
        send_window(REGION_START);
        build_id3v2(BYTE_ALL_ONES, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 0, 0);
        send_window(REGION_START);
        build_id3v2(8'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 0, 0);
        win_bytes[4] = BYTE_ALL_ONES;
        send_window(REGION_START);
        build_id3v2(8'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 0, 0);
        send_window(REGION_START);
        build_id3v2(8'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 5, 1);
        send_window(REGION_START);
        build_id3v2(8'd3, ID3_FOOTER_BIT, 8'h00, 8'h00, 8'h00, 8'h05, 3, 0);
        send_window(REGION_START);
        build_id3v2(8'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0);
        trim_window(ID3V2_HDR_LAST);
        send_window(REGION_START);

        // APE: largest length, footer version 1000, bad version, nonzero
        // reserved byte, one byte short, size zero with header bit
        build_ape(APE_VER_2000, 32'hffff_ffff, APE_HEADER_BIT, 0);
        send_window(REGION_START);
        build_ape(APE_VER_1000, 32'd1234, APE_HEADER_BIT, 2);
        send_window(REGION_APE_FOOTER);
        build_ape(APE_VER_1000 + 32'd1, 32'd77, 8'h00, 0);
        send_window(REGION_APE_FOOTER);
        build_ape(APE_VER_2000, 32'd5, 8'h00, 0);
        win_bytes[APE_HDR_LAST] = 8'h01;
        send_window(REGION_APE_FOOTER);
        build_ape(APE_VER_2000, 32'd5, APE_HEADER_BIT, 0);
        trim_window(APE_HDR_LAST);
        send_window(REGION_APE_FOOTER);
        build_ape(APE_VER_2000, 32'd0, APE_HEADER_BIT, 0);
        send_window(REGION_APE_FOOTER);
        build_ape(APE_VER_1000, 32'd7, 8'h00, 0);
        send_window(REGION_ID3V1);

        // ID3v1 and extended ID3v1, exact and short
        build_tag(1'b0, 0);
        send_window(REGION_ID3V1);
        build_tag(1'b0, 0);
        trim_window(ID3V1_HDR_LAST);
        send_window(REGION_ID3V1);
        build_tag(1'b1, 0);
        send_window(REGION_ID3V1_EXT);
        build_tag(1'b0, 0);
        send_window(REGION_ID3V1_EXT);
        build_tag(1'b1, 3);
        send_window(REGION_ID3V1);

        // Single byte window, then a window that runs past the size limit
        // with padding all the way
        win_bytes.push_back(8'hff);
        send_window(REGION_APE_FOOTER);
        build_id3v2(8'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, WINDOW_BYTES - 7, 0);
        send_window(REGION_START);

        // Random windows: mostly well-formed, some broken, some noise
        bytes_sent   = 0;
        windows_sent = 0;
        while (bytes_sent < RANDOM_BYTES || windows_sent < RANDOM_WINDOWS) begin
            if ($urandom_range(0, 5) == 0) send_calm = !send_calm;
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                if ($urandom_range(0, 7) == 0) begin
                    build_id3v2(($urandom_range(0, 15) == 0) ? BYTE_ALL_ONES
                                                               : 8'($urandom_range(0, 254)),
                                8'($urandom), 8'($urandom_range(0, 127)),
                                8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)),
                                8'($urandom_range(0, 127)), 0, $urandom_range(0, 4));
                end else begin
                    build_id3v2(($urandom_range(0, 15) == 0) ? BYTE_ALL_ONES
                                                               : 8'($urandom_range(0, 254)),
                                8'($urandom), 8'h00, 8'h00, 8'h00,
                                8'($urandom_range(0, 40)), $urandom_range(0, 6),
                                $urandom_range(0, 4));
                end
                rgn = REGION_START;
            end else if (pick < 45) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: ape_ver = APE_VER_1000;
                    4, 5, 6, 7: ape_ver = APE_VER_2000;
                    8:          ape_ver = APE_VER_2000 - 32'd1;
                    default:    ape_ver = $urandom;
                endcase
                build_ape(ape_ver, ($urandom_range(0, 1) == 0) ? $urandom
                                                                : $urandom_range(0, 4096),
                          8'($urandom), $urandom_range(0, 8));
                rgn = ($urandom_range(0, 1) == 0) ? REGION_START : REGION_APE_FOOTER;
            end else if (pick < 58) begin
                build_tag($urandom_range(0, 3) == 0, $urandom_range(0, 8));
                rgn = REGION_ID3V1;
            end else if (pick < 70) begin
                build_tag($urandom_range(0, 3) != 0, $urandom_range(0, 8));
                rgn = REGION_ID3V1_EXT;
            end else begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                repeat (n) win_bytes.push_back(8'($urandom));
                case ($urandom_range(0, 3))
                    0:       win_bytes[0] = ID3_MAGIC[23:16];
                    1:       win_bytes[0] = APE_MAGIC[63:56];
                    2:       win_bytes[0] = TAG_MAGIC[23:16];
                    default: ;
                endcase
                rgn = region_t'($urandom_range(0, 3));
            end

            // Break some well-formed windows: wrong region, bad byte, cut short
            if (pick < 70) begin
                if ($urandom_range(0, 9) == 0) rgn = region_t'($urandom_range(0, 3));
                if ($urandom_range(0, 6) == 0) begin
                    lim = (win_bytes.size() < HDR_DEPTH) ? win_bytes.size() : HDR_DEPTH;
                    win_bytes[$urandom_range(0, lim - 1)] = 8'($urandom);
                end
                if ($urandom_range(0, 9) == 0) trim_window($urandom_range(1, win_bytes.size()));
            end
            send_window(rgn);
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then allow for stragglers
        @(posedge aclk);
        while (tags_pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (fail_count == 0 && tags_pending == 0) begin
            $display("PASS audio_tag_header_recognizer");
        end else begin
            $display("FAIL audio_tag_header_recognizer");
        end
        $finish;
    end

endmodule
